### hdl/mp1d_pkg.sv
// Shared constants and types for the 1-D max pooling block.
package mp1d_pkg;

	localparam int KERNEL_BITS    = 5;
	localparam int STRIDE_BITS    = 8;
	localparam int FRAME_BITS     = 9;
	localparam int OFFSET_BITS    = 4;
	localparam int INDEX_BITS     = 8;
	localparam int FRAME_CNT_BITS = 16;
	localparam int ADDR_BITS      = 4;
	localparam int DATA_BITS      = 32;

	localparam logic [FRAME_CNT_BITS-1:0] FRAME_SAT = '1;

	localparam logic [KERNEL_BITS-1:0] KERNEL_RESET = 5'd2;
	localparam logic [STRIDE_BITS-1:0] STRIDE_RESET = 8'd1;
	localparam logic [FRAME_BITS-1:0]  FRAME_RESET  = 9'd1;

	// result queue between the compare stage and the output port
	localparam int                OUT_DEPTH    = 3;
	localparam int                OUT_PTR_BITS = 2;
	localparam logic [OUT_PTR_BITS-1:0] OUT_LAST = 2'(OUT_DEPTH - 1);

	typedef enum logic [1:0] {
		REG_KERNEL_WIDTH = 2'd0,
		REG_STRIDE       = 2'd1,
		REG_FRAME_SIZE   = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [OFFSET_BITS-1:0] max_offset;
		logic [INDEX_BITS-1:0]  feature_index;
		logic                   last_of_frame;
	} res_meta_t;

endpackage

### hdl/mp1d_in_if.sv
// Sample request channel: valid/ready with sample and sequence-end flag.
interface mp1d_in_if #(
	parameter int SAMPLE_BITS = 16
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          end_of_sequence;

	modport source (output valid, sample, end_of_sequence, input ready);
	modport sink   (input valid, sample, end_of_sequence, output ready);
endinterface

### hdl/mp1d_out_if.sv
// Result request channel: valid/ready with pooled maximum and its position.
interface mp1d_out_if #(
	parameter int SAMPLE_BITS = 16
) ();
	import mp1d_pkg::*;

	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] max_value;
	logic [OFFSET_BITS-1:0]        max_offset;
	logic [INDEX_BITS-1:0]         feature_index;
	logic                          last_of_frame;

	modport source (output valid, max_value, max_offset, feature_index, last_of_frame,
		input ready);
	modport sink   (input valid, max_value, max_offset, feature_index, last_of_frame,
		output ready);
endinterface

### hdl/mp1d_ram.sv
// Generic simple dual-port RAM, registered read, read returns old data on collision.
module mp1d_ram #(
	parameter int WIDTH = 20,
	parameter int DEPTH = 256
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### hdl/max_pool_1d_forward.sv
// Streaming 1-D max pooling with first-occurrence argmax, top level.
// A result passes through stage 1 and the output queue after its sample is taken.
// Throughput: one sample per cycle while the queue has room; set by the single read
//   and write port of each window lane RAM, read at accept, written back in stage 1.
// Reset (arst_n low, async): registers return to kernel 2, stride 1, frame 1,
//   counters restart at frame 0; lane RAM contents stay undefined until written.
module max_pool_1d_forward #(
	parameter int MAX_FEATURES = 256,
	parameter int MAX_KERNEL   = 16,
	parameter int SAMPLE_BITS  = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	mp1d_in_if.sink                           samples,
	mp1d_out_if.source                        results,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [mp1d_pkg::ADDR_BITS-1:0]    paddr,
	input  logic [mp1d_pkg::DATA_BITS-1:0]    pwdata,
	output logic [mp1d_pkg::DATA_BITS-1:0]    prdata,
	output logic                              pready
);
	import mp1d_pkg::*;

	localparam int KW = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;    // window offset bits
	localparam int FW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1; // feature bits
	localparam int DW = SAMPLE_BITS + KW;                             // lane RAM word

	// ------------------------------------------------------------------
	// Configuration registers (APB, zero wait state)
	// ------------------------------------------------------------------
	logic [KERNEL_BITS-1:0] kernel_width_q;
	logic [STRIDE_BITS-1:0] stride_q;
	logic [FRAME_BITS-1:0]  frame_size_q;
	logic                   cfg_wr;
	logic                   restart;
	reg_idx_t               cfg_idx;

	assign pready  = 1'b1;
	assign cfg_idx = reg_idx_t'(paddr[ADDR_BITS-1:2]);
	assign cfg_wr  = psel && penable && pwrite;
	// a write to any defined register restarts the sequence
	assign restart = cfg_wr && (cfg_idx == REG_KERNEL_WIDTH || cfg_idx == REG_STRIDE ||
		cfg_idx == REG_FRAME_SIZE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_width_q <= KERNEL_RESET;
			stride_q       <= STRIDE_RESET;
			frame_size_q   <= FRAME_RESET;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_KERNEL_WIDTH: kernel_width_q <= pwdata[KERNEL_BITS-1:0];
				REG_STRIDE:       stride_q       <= pwdata[STRIDE_BITS-1:0];
				REG_FRAME_SIZE:   frame_size_q   <= pwdata[FRAME_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_KERNEL_WIDTH: prdata = DATA_BITS'(kernel_width_q);
			REG_STRIDE:       prdata = DATA_BITS'(stride_q);
			REG_FRAME_SIZE:   prdata = DATA_BITS'(frame_size_q);
			default:          prdata = '0;
		endcase
	end

	// Effective values, clamped; kept as "minus one" so compares stay narrow.
	logic [KW-1:0]          km1;   // last offset of a window
	logic [STRIDE_BITS-1:0] stm1;  // last phase before a new window opens
	logic [FW-1:0]          fsm1;  // last feature of a frame

	always_comb begin
		if (kernel_width_q == '0) begin
			km1 = '0;
		end else if (32'(kernel_width_q) > MAX_KERNEL) begin
			km1 = KW'(MAX_KERNEL - 1);
		end else begin
			km1 = KW'(kernel_width_q - KERNEL_BITS'(1));
		end
		stm1 = (stride_q == '0) ? '0 : stride_q - STRIDE_BITS'(1);
		if (frame_size_q == '0) begin
			fsm1 = '0;
		end else if (32'(frame_size_q) > MAX_FEATURES) begin
			fsm1 = FW'(MAX_FEATURES - 1);
		end else begin
			fsm1 = FW'(frame_size_q - FRAME_BITS'(1));
		end
	end

	// ------------------------------------------------------------------
	// Position tracking and window lanes.
	// Window w lives in lane w mod MAX_KERNEL. Each lane holds whether its
	// window is open and the current frame's offset into it. At most
	// kernel_width windows are open and they are consecutive, so lanes never
	// collide: the lane a new window takes closed on an earlier frame.
	// ------------------------------------------------------------------
	logic [FW-1:0]             feat_q;
	logic [FRAME_CNT_BITS-1:0] frame_q;
	logic [STRIDE_BITS-1:0]    phase_q;  // frame mod stride
	logic [KW-1:0]             slot_q;   // lane of the newest window
	logic [MAX_KERNEL-1:0]     act_q;
	logic [KW-1:0]             dist_q [MAX_KERNEL];

	logic [FW-1:0]             feat;
	logic                      last_feat;
	logic                      live;
	logic                      acc;
	logic                      wrap;
	logic [KW-1:0]             slot_nx;

	assign feat      = (feat_q > fsm1) ? fsm1 : feat_q;
	assign last_feat = (feat == fsm1);
	assign live      = (frame_q != FRAME_SAT);
	assign acc       = samples.valid && samples.ready;
	assign wrap      = (phase_q == stm1);
	assign slot_nx   = (slot_q == KW'(MAX_KERNEL - 1)) ? '0 : slot_q + KW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feat_q  <= '0;
			frame_q <= '0;
			phase_q <= '0;
			slot_q  <= '0;
			act_q   <= MAX_KERNEL'(1);
			for (int s = 0; s < MAX_KERNEL; s++) begin
				dist_q[s] <= '0;
			end
		end else if (restart || (acc && samples.end_of_sequence)) begin
			// frame 0 opens window 0 in lane 0
			feat_q    <= '0;
			frame_q   <= '0;
			phase_q   <= '0;
			slot_q    <= '0;
			act_q     <= MAX_KERNEL'(1);
			dist_q[0] <= '0;
		end else if (acc) begin
			if (!last_feat) begin
				feat_q <= feat + FW'(1);
			end else begin
				feat_q <= '0;
				if (live) begin
					frame_q <= frame_q + FRAME_CNT_BITS'(1);
					phase_q <= wrap ? '0 : phase_q + STRIDE_BITS'(1);
					for (int s = 0; s < MAX_KERNEL; s++) begin
						if (act_q[s] && dist_q[s] == km1) begin
							act_q[s] <= 1'b0;  // window emitted on this frame
						end else begin
							dist_q[s] <= dist_q[s] + KW'(1);
						end
					end
					if (wrap) begin
						slot_q          <= slot_nx;
						act_q[slot_nx]  <= 1'b1;
						dist_q[slot_nx] <= '0;
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: lane RAMs read at accept, compare and write back here.
	// ------------------------------------------------------------------
	logic                          valid_s1;
	logic signed [SAMPLE_BITS-1:0] sample_s1;
	logic [FW-1:0]                 feat_s1;
	logic                          last_s1;
	logic [MAX_KERNEL-1:0]         act_s1;
	logic [KW-1:0]                 dist_s1 [MAX_KERNEL];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			sample_s1 <= samples.sample;
			feat_s1   <= feat;
			last_s1   <= last_feat;
			act_s1    <= live ? act_q : '0;  // saturated frames touch nothing
			for (int s = 0; s < MAX_KERNEL; s++) begin
				dist_s1[s] <= dist_q[s];
			end
		end
	end

	logic [DW-1:0]                 rdata   [MAX_KERNEL];
	logic [DW-1:0]                 wdata   [MAX_KERNEL];
	logic [MAX_KERNEL-1:0]         wen;
	logic [MAX_KERNEL-1:0]         emit;
	logic [DW-1:0]                 held    [MAX_KERNEL];
	logic signed [SAMPLE_BITS-1:0] held_val [MAX_KERNEL];

	// last cycle's writes, for a read that raced its own write-back
	logic [MAX_KERNEL-1:0]         wen_q;
	logic [FW-1:0]                 waddr_q;
	logic [DW-1:0]                 wdata_q [MAX_KERNEL];

	genvar g;
	generate
		for (g = 0; g < MAX_KERNEL; g++) begin : g_lane
			mp1d_ram #(
				.WIDTH (DW),
				.DEPTH (MAX_FEATURES)
			) u_ram (
				.clk   (clk),
				.we    (wen[g]),
				.waddr (feat_s1),
				.wdata (wdata[g]),
				.raddr (feat),
				.rdata (rdata[g])
			);
		end
	endgenerate

	always_comb begin
		for (int s = 0; s < MAX_KERNEL; s++) begin
			held[s]     = (wen_q[s] && waddr_q == feat_s1) ? wdata_q[s] : rdata[s];
			held_val[s] = held[s][DW-1:KW];
			wen[s]      = valid_s1 && act_s1[s];
			// first frame of a window always loads; later only a strictly greater one
			if (dist_s1[s] == '0 || sample_s1 > held_val[s]) begin
				wdata[s] = {sample_s1, dist_s1[s]};
			end else begin
				wdata[s] = held[s];
			end
			emit[s] = wen[s] && (dist_s1[s] == km1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wen_q <= '0;
		end else begin
			wen_q <= wen;
		end
	end

	always_ff @(posedge clk) begin
		waddr_q <= feat_s1;
		for (int s = 0; s < MAX_KERNEL; s++) begin
			wdata_q[s] <= wdata[s];
		end
	end

	// at most one window ends on a frame, so emit is one-hot or zero
	logic                          push;
	logic signed [SAMPLE_BITS-1:0] res_val;
	res_meta_t                     res_meta;
	logic [KW-1:0]                 res_dist;

	assign push = |emit;

	always_comb begin
		res_val  = '0;
		res_dist = '0;
		for (int s = 0; s < MAX_KERNEL; s++) begin
			if (emit[s]) begin
				res_val  = wdata[s][DW-1:KW];
				res_dist = wdata[s][KW-1:0];
			end
		end
		res_meta.max_offset    = OFFSET_BITS'(res_dist);
		res_meta.feature_index = INDEX_BITS'(feat_s1);
		res_meta.last_of_frame = last_s1;
	end

	// ------------------------------------------------------------------
	// Output queue. Stage 1 never stalls; a sample is taken only while the
	// queue can hold what is already in stage 1 plus one more.
	// ------------------------------------------------------------------
	logic signed [SAMPLE_BITS-1:0] oq_val  [OUT_DEPTH];
	res_meta_t                     oq_meta [OUT_DEPTH];
	logic [OUT_PTR_BITS-1:0]       head_q;
	logic [OUT_PTR_BITS-1:0]       tail_q;
	logic [OUT_PTR_BITS-1:0]       cnt_q;
	logic                          pop;
	logic [OUT_PTR_BITS:0]         need;

	assign need          = {1'b0, cnt_q} + (OUT_PTR_BITS + 1)'(push);
	assign samples.ready = (need < (OUT_PTR_BITS + 1)'(OUT_DEPTH));
	assign pop           = results.valid && results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				tail_q <= (tail_q == OUT_LAST) ? '0 : tail_q + OUT_PTR_BITS'(1);
			end
			if (pop) begin
				head_q <= (head_q == OUT_LAST) ? '0 : head_q + OUT_PTR_BITS'(1);
			end
			cnt_q <= cnt_q + OUT_PTR_BITS'(push) - OUT_PTR_BITS'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			oq_val[tail_q]  <= res_val;
			oq_meta[tail_q] <= res_meta;
		end
	end

	assign results.valid         = (cnt_q != '0);
	assign results.max_value     = oq_val[head_q];
	assign results.max_offset    = oq_meta[head_q].max_offset;
	assign results.feature_index = oq_meta[head_q].feature_index;
	assign results.last_of_frame = oq_meta[head_q].last_of_frame;

endmodule

### tb/max_pool_1d_forward_test.sv
// Self-checking testbench for the streaming 1-D max pooling block with argmax.
`timescale 1ns / 100ps

module max_pool_1d_forward_test;

	import mp1d_pkg::*;

	localparam int POOL_FEATURES = 256;
	localparam int POOL_KERNEL   = 16;
	localparam int WORD_BITS     = 16;
	localparam int STORE_SLOTS   = POOL_FEATURES * POOL_KERNEL;
	localparam int SETTLE_CYCLES = 4;          // slack for samples still in stage 1 and the output queue
	localparam int DRAIN_LIMIT   = 4000;       // bounded wait for the last results
	localparam int RUN_LIMIT_NS  = 4_000_000;  // run time limit, far beyond a correct run

	// sender / receiver idling patterns
	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	// one pooled result as it leaves the block
	typedef struct {
		logic signed [WORD_BITS-1:0] max_value;
		logic [OFFSET_BITS-1:0]      max_offset;
		logic [INDEX_BITS-1:0]       feature_index;
		logic                        last_of_frame;
	} pooled_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [ADDR_BITS-1:0] paddr;
	logic [DATA_BITS-1:0] pwdata, prdata;
	logic pready;
	logic take_ready = 1'b0;

	mp1d_in_if  #(.SAMPLE_BITS(WORD_BITS)) sample_bus ();
	mp1d_out_if #(.SAMPLE_BITS(WORD_BITS)) pool_bus ();

	assign pool_bus.ready = take_ready;

	max_pool_1d_forward #(
		.MAX_FEATURES(POOL_FEATURES),
		.MAX_KERNEL  (POOL_KERNEL),
		.SAMPLE_BITS (WORD_BITS)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(sample_bus),
		.results(pool_bus),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	always #2 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor state: register images, the clamped values actually used,
	// stream position, and the per-window running maximum / argmax store.
	// ------------------------------------------------------------------
	logic [KERNEL_BITS-1:0] cfg_kernel;
	logic [STRIDE_BITS-1:0] cfg_stride;
	logic [FRAME_BITS-1:0]  cfg_frame;
	int unsigned kernel_eff, stride_eff, frame_eff;
	int unsigned feat_pos, frame_no;
	logic signed [WORD_BITS-1:0] win_peak [STORE_SLOTS];
	logic [OFFSET_BITS-1:0]      win_peak_at [STORE_SLOTS];

	pooled_t pending_maxima [$];

	int gap_pct   = 0;     // chance in 100 that the sender idles a cycle
	int stall_pct = 0;     // chance in 100 that the receiver stalls a cycle
	int failures  = 0;
	int unsigned samples_sent   = 0;
	int unsigned results_seen   = 0;
	int unsigned settings_tried = 0;

	// Zero and oversized register values fall back to the nearest legal setting.
	function automatic void derive_limits();
		kernel_eff = (cfg_kernel == 0) ? 1 : (cfg_kernel > POOL_KERNEL) ? POOL_KERNEL : cfg_kernel;
		stride_eff = (cfg_stride == 0) ? 1 : cfg_stride;
		frame_eff  = (cfg_frame == 0) ? 1 :
			(cfg_frame > POOL_FEATURES) ? POOL_FEATURES : cfg_frame;
	endfunction

	// Any register write restarts the sequence.
	function automatic void take_reg(reg_idx_t idx, logic [DATA_BITS-1:0] value);
		case (idx)
			REG_KERNEL_WIDTH: cfg_kernel = KERNEL_BITS'(value);
			REG_STRIDE:       cfg_stride = STRIDE_BITS'(value);
			REG_FRAME_SIZE:   cfg_frame  = FRAME_BITS'(value);
			default: ;
		endcase
		derive_limits();
		feat_pos = 0;
		frame_no = 0;
	endfunction

	// Fold one accepted sample into every open window that covers its frame.
	// Window w lives in slot w mod POOL_KERNEL; its first frame (offset 0)
	// always overwrites, later frames only on a strictly greater value, so
	// ties keep the earliest offset. The window whose last frame this is
	// yields one result. Frames at or past the saturated count do nothing.
	function automatic void pool_sample(logic signed [WORD_BITS-1:0] value, logic seq_end);
		int unsigned feat, frame, d, start, slot, idx;
		pooled_t res;
		feat  = feat_pos;
		frame = frame_no;
		if (feat >= frame_eff) feat = frame_eff - 1;
		if (frame < FRAME_SAT) begin
			for (d = 0; d < kernel_eff; d++) begin
				if (d > frame) break;
				start = frame - d;
				if (start % stride_eff != 0) continue;
				slot = (start / stride_eff) % POOL_KERNEL;
				idx  = slot * POOL_FEATURES + feat;
				if (d == 0 || value > win_peak[idx]) begin
					win_peak[idx]    = value;
					win_peak_at[idx] = OFFSET_BITS'(d);
				end
				if (d == kernel_eff - 1) begin
					res.max_value     = win_peak[idx];
					res.max_offset    = win_peak_at[idx];
					res.feature_index = INDEX_BITS'(feat);
					res.last_of_frame = (feat == frame_eff - 1);
					pending_maxima.push_back(res);
				end
			end
		end
		// sequence end wins over frame advance; incomplete windows are dropped
		if (seq_end) begin
			feat_pos = 0;
			frame_no = 0;
		end else if (feat + 1 >= frame_eff) begin
			feat_pos = 0;
			if (frame_no < FRAME_SAT) frame_no++;
		end else begin
			feat_pos = feat + 1;
		end
	endfunction

	// Mix of full-range words, a narrow band that makes ties, and the extremes.
	function automatic logic signed [WORD_BITS-1:0] pick_sample();
		int unsigned roll;
		roll = $urandom_range(0, 9);
		if (roll < 5) return WORD_BITS'($urandom);
		if (roll < 8) return WORD_BITS'(int'($urandom_range(0, 6)) - 3);
		if (roll == 8) return {1'b0, {(WORD_BITS-1){1'b1}}};
		return {1'b1, {(WORD_BITS-1){1'b0}}};
	endfunction

	// ------------------------------------------------------------------
	// Result side: random back-pressure, and a check at the falling edge
	// of every request that the next rising edge will accept. Inputs only
	// change at rising edges, so the values seen here are the ones taken.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		take_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	always @(negedge clk) begin : check_pooled
		pooled_t want;
		if (arst_n === 1'b1 && pool_bus.valid === 1'b1 && pool_bus.ready === 1'b1) begin
			if (pending_maxima.size() == 0) begin
				$error("unexpected result: max_value %0d feature_index %0d",
					pool_bus.max_value, pool_bus.feature_index);
				failures++;
			end else begin
				want = pending_maxima.pop_front();
				results_seen++;
				if (pool_bus.max_value !== want.max_value) begin
					$error("max_value: expected %0d, got %0d", want.max_value, pool_bus.max_value);
					failures++;
				end
				if (pool_bus.max_offset !== want.max_offset) begin
					$error("max_offset: expected %0d, got %0d", want.max_offset,
						pool_bus.max_offset);
					failures++;
				end
				if (pool_bus.feature_index !== want.feature_index) begin
					$error("feature_index: expected %0d, got %0d", want.feature_index,
						pool_bus.feature_index);
					failures++;
				end
				if (pool_bus.last_of_frame !== want.last_of_frame) begin
					$error("last_of_frame: expected %0b, got %0b", want.last_of_frame,
						pool_bus.last_of_frame);
					failures++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Sample side. Every task starts and ends just after a rising edge,
	// and each drives a signal at most once per edge.
	// ------------------------------------------------------------------
	task automatic push_sample(input logic signed [WORD_BITS-1:0] value, input logic seq_end);
		while ($urandom_range(0, 99) < gap_pct) begin
			sample_bus.valid <= 1'b0;
			@(posedge clk);
		end
		sample_bus.valid           <= 1'b1;
		sample_bus.sample          <= value;
		sample_bus.end_of_sequence <= seq_end;
		@(negedge clk);
		while (sample_bus.ready !== 1'b1) @(negedge clk);
		@(posedge clk);
		// request taken at this edge
		pool_sample(value, seq_end);
		samples_sent++;
	endtask

	// Sender goes quiet until every predicted result has come out.
	task automatic wait_drained();
		sample_bus.valid <= 1'b0;
		do @(posedge clk); while (pending_maxima.size() != 0);
	endtask

	// Write a register, then read it back in a back-to-back transfer.
	task automatic write_reg(input reg_idx_t idx, input logic [DATA_BITS-1:0] value);
		logic [DATA_BITS-1:0] want, got;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		while (pready !== 1'b1) @(negedge clk);
		@(posedge clk);
		take_reg(idx, value);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		while (pready !== 1'b1) @(negedge clk);
		got = prdata;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_KERNEL_WIDTH: want = DATA_BITS'(cfg_kernel);
			REG_STRIDE:       want = DATA_BITS'(cfg_stride);
			default:          want = DATA_BITS'(cfg_frame);
		endcase
		if (got !== want) begin
			$error("%s readback: expected %0h, got %0h", idx.name(), want, got);
			failures++;
		end
		@(posedge clk);
	endtask

	// New setting only once the pipe is empty; samples that yield nothing may
	// still be in flight after the last result, hence the settle cycles.
	task automatic configure(input int unsigned kw, input int unsigned st, input int unsigned fs);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(REG_KERNEL_WIDTH, DATA_BITS'(kw));
		write_reg(REG_STRIDE, DATA_BITS'(st));
		write_reg(REG_FRAME_SIZE, DATA_BITS'(fs));
		settings_tried++;
	endtask

	task automatic set_idling(input idle_mode_t mode);
		case (mode)
			IDLE_SENDER:   begin gap_pct = 61; stall_pct = 0;  end
			IDLE_RECEIVER: begin gap_pct = 0;  stall_pct = 61; end
			IDLE_BOTH:     begin gap_pct = 31; stall_pct = 31; end
			default:       begin gap_pct = 0;  stall_pct = 0;  end
		endcase
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset setting (kernel 2, stride 1, one feature): extremes, a tie at the
	// minimum, a sequence shorter than the kernel, and a mid-stream pause.
	task automatic test_reset_defaults();
		set_idling(IDLE_NONE);
		push_sample(16'sh7FFF, 1'b0);
		push_sample(16'sh8000, 1'b0);   // 7FFF wins at offset 0
		push_sample(16'sh8000, 1'b0);   // tie, earliest offset
		push_sample(16'sh0000, 1'b0);
		push_sample(16'shFFFF, 1'b1);   // result on the sequence-end sample
		push_sample(16'sh0005, 1'b1);   // one frame only: nothing comes out
		wait_drained();
		push_sample(16'sh8000, 1'b0);
		push_sample(16'sh8000, 1'b1);
	endtask

	// Overlapping windows (kernel 3, stride 2, two features) with ties, and a
	// trailing window cut off by the sequence end.
	task automatic test_overlap_ties();
		configure(3, 2, 2);
		push_sample(16'sd7, 1'b0);   push_sample(-16'sd3, 1'b0);
		push_sample(16'sd7, 1'b0);   push_sample(16'sd9, 1'b0);
		push_sample(16'sd2, 1'b0);   push_sample(16'sd9, 1'b0);
		push_sample(-16'sd1, 1'b0);  push_sample(16'sd100, 1'b0);
		push_sample(16'sd2, 1'b0);   push_sample(-16'sd100, 1'b1);
	endtask

	// Random content over a series of settings: mostly whole sequences long
	// enough to close windows, some cut short, some with no end flag at all.
	task automatic run_pool_phase(input int unsigned kw, input int unsigned st,
			input int unsigned fs, input int unsigned budget, input idle_mode_t mode);
		int unsigned sent, total, kind, hi, i;
		logic closed;
		configure(kw, st, fs);
		set_idling(mode);
		sent = 0;
		while (sent < budget) begin
			kind = $urandom_range(0, 9);
			if (kind < 8) begin
				hi = (2 * stride_eff > 24) ? 24 : 2 * stride_eff;
				total  = $urandom_range(kernel_eff, kernel_eff + hi) * frame_eff;
				closed = 1'b1;
			end else if (kind == 8) begin
				total  = $urandom_range(1, (kernel_eff + 1) * frame_eff);
				closed = 1'b1;
			end else begin
				total  = $urandom_range(1, 2 * frame_eff);
				closed = 1'b0;
			end
			for (i = 0; i < total && sent < budget; i++) begin
				push_sample(pick_sample(), closed && (i == total - 1));
				sent++;
			end
			if ($urandom_range(0, 15) == 0) wait_drained();
		end
	endtask

	task automatic test_random_settings();
		int unsigned kern [9];
		int unsigned strd [9];
		int unsigned fsz  [9];
		int unsigned quota [9];
		int p;
		// zero and max values of every register, and over-range kernel and frame sizes, appear here
		kern  = '{1, 0, 16, 31, 4, 1, 5, 8, 1};
		strd  = '{1, 0, 1, 3, 255, 2, 2, 8, 1};
		fsz   = '{1, 0, 2, 3, 4, 511, 7, 5, 256};
		quota = '{150, 150, 250, 250, 200, 300, 250, 200, 200};
		for (p = 0; p < 9; p++) begin
			run_pool_phase(kern[p], strd[p], fsz[p], quota[p], idle_mode_t'(p % 4));
		end
	endtask

	initial begin
		#(RUN_LIMIT_NS);
		$display("status: fail");
		$finish;
	end

	initial begin
		int n;
		arst_n  = 1'b0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		sample_bus.valid           = 1'b0;
		sample_bus.sample          = '0;
		sample_bus.end_of_sequence = 1'b0;
		cfg_kernel = KERNEL_RESET;
		cfg_stride = STRIDE_RESET;
		cfg_frame  = FRAME_RESET;
		derive_limits();
		feat_pos = 0;
		frame_no = 0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_overlap_ties();
		test_random_settings();

		// let the tail drain, bounded, then check nothing is left over
		sample_bus.valid <= 1'b0;
		for (n = 0; n < DRAIN_LIMIT && pending_maxima.size() != 0; n++) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_maxima.size() != 0) begin
			$error("%0d expected results never arrived", pending_maxima.size());
			failures++;
		end

		$display("Ran %0d samples over %0d register settings, %0d pooled results compared,",
			samples_sent, settings_tried + 1, results_seen);
		$display("with clamped register values, cut-short sequences and four idling mixes.");
		if (failures == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
